### rtl/core/bsc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
package bsc_pkg;

  localparam int unsigned T_OFFSET  = 128000;
  localparam int unsigned P_BASE    = 1048576;
  localparam int unsigned P_SCALE   = 3125;
  localparam int unsigned T_ROUND   = 128;
  localparam int unsigned T_MUL_SH  = 2;   // x*5 = x + (x << 2)
  localparam int unsigned SH_P4     = 35;
  localparam int unsigned SH_ONE    = 47;
  localparam int unsigned SH_P1     = 33;
  localparam int unsigned SH_P      = 31;
  localparam int unsigned DIV_W     = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_A  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_B  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_C  = 8'd3;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic        [31:0] pressure_q24_8;
    logic               divide_by_zero;
  } out_item_t;

  // Unpacked calibration words
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } cal_t;

  // Temperature results riding along the pressure path
  typedef struct packed {
    logic signed [23:0] tc;
    logic signed [31:0] fine;
    logic               dz;
  } side_t;

endpackage

### rtl/core/barometric_sensor_compensation.sv
// Top level of the barometric pressure/temperature compensation pipeline.
//
//  channel | ports                              | direction | transaction
//  --------+------------------------------------+-----------+------------------------------
//  in      | in_valid, in_ready, in_data        | input     | one raw temperature/pressure
//  out     | out_valid, out_ready, out_data     | output    | one compensated result
//  cfg     | cfg_valid, cfg_ready, cfg_index,   | input     | one 48-bit calibration write
//          | cfg_data                           |           |
//
// One transaction enters per cycle while the output is not stalled; the pipeline holds
// 5 temperature stages, 9 polynomial stages, 66 divider stages (one quotient
// bit per stage over 64 bits) and 6 correction stages including the output register.
// Reset (rst_n low, synchronous) clears all valid bits and calibration registers.
// When the output holds a result that is not taken, the whole pipeline freezes;
// nothing is dropped or repeated, and in_ready follows out_ready in that case.
module barometric_sensor_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bsc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bsc_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bsc_pkg::CFG_DAT_W-1:0]       cfg_data
);

  // calibration registers
  logic [bsc_pkg::CFG_DAT_W-1:0] temp_cal_r, press_a_r, press_b_r, press_c_r;
  bsc_pkg::cal_t                 cal;

  // global advance: move when the output slot is free or being drained
  logic            en;

  logic            t_valid, c_valid, d_valid;
  bsc_pkg::side_t  t_side, c_side, d_side;
  logic [19:0]     t_raw_p;
  logic [63:0]     c_num, c_den, d_quo;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bsc_pkg::REG_TEMP_CAL: temp_cal_r <= cfg_data;
        bsc_pkg::REG_PRESS_A:  press_a_r  <= cfg_data;
        bsc_pkg::REG_PRESS_B:  press_b_r  <= cfg_data;
        bsc_pkg::REG_PRESS_C:  press_c_r  <= cfg_data;
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  // word unpack: first word in the low 16 bits
  assign cal.t1 = temp_cal_r[15:0];
  assign cal.t2 = $signed(temp_cal_r[31:16]);
  assign cal.t3 = $signed(temp_cal_r[47:32]);
  assign cal.p1 = press_a_r[15:0];
  assign cal.p2 = $signed(press_a_r[31:16]);
  assign cal.p3 = $signed(press_a_r[47:32]);
  assign cal.p4 = $signed(press_b_r[15:0]);
  assign cal.p5 = $signed(press_b_r[31:16]);
  assign cal.p6 = $signed(press_b_r[47:32]);
  assign cal.p7 = $signed(press_c_r[15:0]);
  assign cal.p8 = $signed(press_c_r[31:16]);
  assign cal.p9 = $signed(press_c_r[47:32]);

  // 32-bit temperature path
  bsc_temp u_temp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cal       (cal),
    .out_valid (t_valid),
    .out_side  (t_side),
    .out_raw_p (t_raw_p)
  );

  // 64-bit polynomial: builds the dividend and divisor
  bsc_coef u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t_valid),
    .in_side   (t_side),
    .in_raw_p  (t_raw_p),
    .cal       (cal),
    .out_valid (c_valid),
    .out_side  (c_side),
    .out_num   (c_num),
    .out_den   (c_den)
  );

  // pipelined signed division; flags a zero divisor
  bsc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (c_valid),
    .in_side   (c_side),
    .in_num    (c_num),
    .in_den    (c_den),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quo   (d_quo)
  );

  // final correction terms and output register
  bsc_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_p      (d_quo),
    .cal       (cal),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // temperature fields must stay paired through the pressure pipeline
  logic [31:0] tc_chk;
  assign tc_chk = 32'(out_data.fine_temperature) * 32'd5 + 32'(bsc_pkg::T_ROUND);

  a_dz_zero_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_by_zero |-> out_data.pressure_q24_8 == 32'd0)
    else $error("pressure not forced to zero on zero divisor");

  a_tc_matches_fine: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.temperature_centi == $signed(tc_chk[31:8]))
    else $error("temperature fields out of step");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_cfg_unknown_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_index != bsc_pkg::REG_TEMP_CAL && cfg_index != bsc_pkg::REG_PRESS_A &&
    cfg_index != bsc_pkg::REG_PRESS_B && cfg_index != bsc_pkg::REG_PRESS_C
    |=> $stable(temp_cal_r) && $stable(press_a_r) && $stable(press_b_r) && $stable(press_c_r))
    else $error("write to unknown index changed calibration");

endmodule

### rtl/core/bsc_temp.sv
// Temperature path: fine temperature and centi-degree output, five stages.
module bsc_temp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  bsc_pkg::in_item_t  in_data,
  input  bsc_pkg::cal_t      cal,
  output logic               out_valid,
  output bsc_pkg::side_t     out_side,
  output logic [19:0]        out_raw_p
);

  logic [4:0]  vld_r;
  logic [19:0] rp_r [0:4];
  logic [31:0] x1_r, d_r, m1_r, dd_r, a_r, e_r, fine_r, fine4_r;
  logic [23:0] tc_r;
  logic [31:0] x1_nxt, d_nxt, m1_nxt, dd_nxt, a_nxt, e_nxt, fine_nxt, t5_nxt;

  always_comb begin
    x1_nxt   = 32'(in_data.raw_temperature >> 3) - (32'(cal.t1) << 1);
    d_nxt    = 32'(in_data.raw_temperature >> 4) - 32'(cal.t1);
    m1_nxt   = x1_r * 32'(cal.t2);
    dd_nxt   = d_r * d_r;
    a_nxt    = 32'($signed(m1_r) >>> 11);
    e_nxt    = 32'($signed(dd_r) >>> 12) * 32'(cal.t3);
    fine_nxt = a_r + 32'($signed(e_r) >>> 14);
    t5_nxt   = fine_r + (fine_r << bsc_pkg::T_MUL_SH) + 32'(bsc_pkg::T_ROUND);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r    <= x1_nxt;
      d_r     <= d_nxt;
      m1_r    <= m1_nxt;
      dd_r    <= dd_nxt;
      a_r     <= a_nxt;
      e_r     <= e_nxt;
      fine_r  <= fine_nxt;
      fine4_r <= fine_r;
      tc_r    <= t5_nxt[31:8];
      rp_r[0] <= in_data.raw_pressure;
      for (int i = 1; i < 5; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
    end
  end

  assign out_valid     = vld_r[4];
  assign out_side.tc   = tc_r;
  assign out_side.fine = fine4_r;
  assign out_side.dz   = 1'b0;
  assign out_raw_p     = rp_r[4];

endmodule

### rtl/core/bsc_coef.sv
// Pressure polynomial up to the divider: dividend and divisor, nine stages.
module bsc_coef (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  bsc_pkg::side_t  in_side,
  input  logic [19:0]     in_raw_p,
  input  bsc_pkg::cal_t   cal,
  output logic            out_valid,
  output bsc_pkg::side_t  out_side,
  output logic [63:0]     out_num,
  output logic [63:0]     out_den
);

  logic [8:0]         vld_r;
  bsc_pkg::side_t     side_r [0:8];
  logic [19:0]        rp_r   [0:5];

  logic signed [32:0] v_r;
  logic [63:0]        sq_r;
  logic signed [48:0] vp5_r, vp2_r, vp5b_r, vp2b_r;
  logic signed [48:0] l6_r, l3_r;
  logic [31:0]        h6_r, h3_r;
  logic [63:0]        v2_r, v1a_r, x_r, v2b_r, v2c_r;
  logic [47:0]        xl_r;
  logic [31:0]        xh_r;
  logic [63:0]        den_r, num_r, den7_r, num8_r, den8_r;
  logic [43:0]        nl_r;
  logic [31:0]        nh_r;

  logic signed [32:0] v_nxt;
  logic signed [65:0] sq_full;
  logic signed [48:0] vp5_nxt, vp2_nxt, l6_nxt, l3_nxt;
  logic [31:0]        h6_nxt, h3_nxt, xh_nxt, nh_nxt;
  logic [63:0]        q6, q3, v2_nxt, v1a_nxt, x_nxt, prod, den_nxt, num_nxt, num8_nxt;
  logic [47:0]        xl_nxt;
  logic [43:0]        nl_nxt;

  always_comb begin
    v_nxt    = 33'(in_side.fine) - 33'(bsc_pkg::T_OFFSET);
    sq_full  = v_r * v_r;
    vp5_nxt  = v_r * cal.p5;
    vp2_nxt  = v_r * cal.p2;
    l6_nxt   = $signed({1'b0, sq_r[31:0]}) * cal.p6;
    l3_nxt   = $signed({1'b0, sq_r[31:0]}) * cal.p3;
    h6_nxt   = sq_r[63:32] * 32'(cal.p6);
    h3_nxt   = sq_r[63:32] * 32'(cal.p3);
    q6       = {h6_r, 32'b0} + 64'(l6_r);
    q3       = {h3_r, 32'b0} + 64'(l3_r);
    v2_nxt   = q6 + (64'(vp5b_r) << 17) + (64'(cal.p4) << bsc_pkg::SH_P4);
    v1a_nxt  = 64'($signed(q3) >>> 8) + (64'(vp2b_r) << 12);
    x_nxt    = v1a_r + (64'd1 << bsc_pkg::SH_ONE);
    xl_nxt   = x_r[31:0] * cal.p1;
    xh_nxt   = x_r[63:32] * 32'(cal.p1);
    prod     = {xh_r, 32'b0} + 64'(xl_r);
    den_nxt  = 64'($signed(prod) >>> bsc_pkg::SH_P1);
    num_nxt  = ((64'(bsc_pkg::P_BASE) - 64'(rp_r[5])) << bsc_pkg::SH_P) - v2c_r;
    nl_nxt   = num_r[31:0] * 12'(bsc_pkg::P_SCALE);
    nh_nxt   = num_r[63:32] * 32'(bsc_pkg::P_SCALE);
    num8_nxt = {nh_r, 32'b0} + 64'(nl_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      rp_r[0]   <= in_raw_p;
      for (int i = 1; i < 9; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        rp_r[i] <= rp_r[i-1];
      end
      v_r    <= v_nxt;
      sq_r   <= sq_full[63:0];
      vp5_r  <= vp5_nxt;
      vp2_r  <= vp2_nxt;
      l6_r   <= l6_nxt;
      l3_r   <= l3_nxt;
      h6_r   <= h6_nxt;
      h3_r   <= h3_nxt;
      vp5b_r <= vp5_r;
      vp2b_r <= vp2_r;
      v2_r   <= v2_nxt;
      v1a_r  <= v1a_nxt;
      x_r    <= x_nxt;
      v2b_r  <= v2_r;
      xl_r   <= xl_nxt;
      xh_r   <= xh_nxt;
      v2c_r  <= v2b_r;
      den_r  <= den_nxt;
      num_r  <= num_nxt;
      nl_r   <= nl_nxt;
      nh_r   <= nh_nxt;
      den7_r <= den_r;
      num8_r <= num8_nxt;
      den8_r <= den7_r;
    end
  end

  assign out_valid = vld_r[8];
  assign out_side  = side_r[8];
  assign out_num   = num8_r;
  assign out_den   = den8_r;

endmodule

### rtl/core/bsc_div.sv
// Truncating signed 64-bit divider, one quotient bit per stage.
module bsc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  bsc_pkg::side_t  in_side,
  input  logic [63:0]     in_num,
  input  logic [63:0]     in_den,
  output logic            out_valid,
  output bsc_pkg::side_t  out_side,
  output logic [63:0]     out_quo
);

  logic [bsc_pkg::DIV_W+1:0]  vld_r;
  bsc_pkg::side_t             side_r [0:bsc_pkg::DIV_W+1];
  logic [bsc_pkg::DIV_W-1:0]  rem_r  [0:bsc_pkg::DIV_W];
  logic [bsc_pkg::DIV_W-1:0]  dvd_r  [0:bsc_pkg::DIV_W];
  logic [bsc_pkg::DIV_W-1:0]  ad_r   [0:bsc_pkg::DIV_W];
  logic                       neg_r  [0:bsc_pkg::DIV_W];
  logic [bsc_pkg::DIV_W-1:0]  quo_r;
  bsc_pkg::side_t             side_nxt;

  always_comb begin
    side_nxt    = in_side;
    side_nxt.dz = (in_den == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[bsc_pkg::DIV_W:0], in_valid};
    end
  end

  // magnitude stage
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      rem_r[0]  <= '0;
      dvd_r[0]  <= in_num[bsc_pkg::DIV_W-1] ? ('0 - in_num) : in_num;
      ad_r[0]   <= in_den[bsc_pkg::DIV_W-1] ? ('0 - in_den) : in_den;
      neg_r[0]  <= in_num[bsc_pkg::DIV_W-1] ^ in_den[bsc_pkg::DIV_W-1];
    end
  end

  for (genvar k = 1; k <= bsc_pkg::DIV_W; k++) begin : g_step
    logic [bsc_pkg::DIV_W:0] trial;
    logic [bsc_pkg::DIV_W:0] diff;
    logic                    ge;

    always_comb begin
      trial = {rem_r[k-1], dvd_r[k-1][bsc_pkg::DIV_W-1]};
      diff  = trial - {1'b0, ad_r[k-1]};
      ge    = !diff[bsc_pkg::DIV_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[bsc_pkg::DIV_W-1:0] : trial[bsc_pkg::DIV_W-1:0];
        dvd_r[k]  <= {dvd_r[k-1][bsc_pkg::DIV_W-2:0], ge};
        ad_r[k]   <= ad_r[k-1];
        neg_r[k]  <= neg_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // sign fix-up
  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= neg_r[bsc_pkg::DIV_W] ? ('0 - dvd_r[bsc_pkg::DIV_W]) : dvd_r[bsc_pkg::DIV_W];
      side_r[bsc_pkg::DIV_W+1] <= side_r[bsc_pkg::DIV_W];
    end
  end

  assign out_valid = vld_r[bsc_pkg::DIV_W+1];
  assign out_side  = side_r[bsc_pkg::DIV_W+1];
  assign out_quo   = quo_r;

endmodule

### rtl/core/bsc_post.sv
// Pressure correction after division and output register, six stages.
module bsc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  bsc_pkg::side_t     in_side,
  input  logic [63:0]        in_p,
  input  bsc_pkg::cal_t      cal,
  output logic               out_valid,
  output bsc_pkg::out_item_t out_data
);

  logic [4:0]          vld_r;
  logic                ovld_r;
  bsc_pkg::side_t      side_r [0:4];
  logic [63:0]         p_r    [0:3];
  bsc_pkg::out_item_t  odat_r;

  logic [63:0]         ll_r, psq_r, w2_r, w2b_r, w2c_r, w1_r, s_r;
  logic [31:0]         lh_r, h8_r, h9_r;
  logic signed [48:0]  l8_r, l9_r;

  logic [63:0]         ps, ll_nxt, psq_nxt, w2s, w2_nxt, w1s, w1_nxt, s_nxt, res;
  logic [31:0]         lh_nxt, h8_nxt, h9_nxt;
  logic signed [48:0]  l8_nxt, l9_nxt;

  always_comb begin
    ps      = 64'($signed(in_p) >>> 13);
    ll_nxt  = ps[31:0] * ps[31:0];
    lh_nxt  = ps[31:0] * ps[63:32];
    l8_nxt  = $signed({1'b0, in_p[31:0]}) * cal.p8;
    h8_nxt  = in_p[63:32] * 32'(cal.p8);
    psq_nxt = ll_r + {lh_r[30:0], 33'b0};
    w2s     = {h8_r, 32'b0} + 64'(l8_r);
    w2_nxt  = 64'($signed(w2s) >>> 19);
    l9_nxt  = $signed({1'b0, psq_r[31:0]}) * cal.p9;
    h9_nxt  = psq_r[63:32] * 32'(cal.p9);
    w1s     = {h9_r, 32'b0} + 64'(l9_r);
    w1_nxt  = 64'($signed(w1s) >>> 25);
    s_nxt   = p_r[3] + w1_r + w2c_r;
    res     = 64'($signed(s_r) >>> 8) + (64'(cal.p7) << 4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else if (en) begin
      vld_r  <= {vld_r[3:0], in_valid};
      ovld_r <= vld_r[4];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      p_r[0]    <= in_p;
      for (int i = 1; i < 5; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int i = 1; i < 4; i++) begin
        p_r[i] <= p_r[i-1];
      end
      ll_r  <= ll_nxt;
      lh_r  <= lh_nxt;
      l8_r  <= l8_nxt;
      h8_r  <= h8_nxt;
      psq_r <= psq_nxt;
      w2_r  <= w2_nxt;
      l9_r  <= l9_nxt;
      h9_r  <= h9_nxt;
      w2b_r <= w2_r;
      w2c_r <= w2b_r;
      w1_r  <= w1_nxt;
      s_r   <= s_nxt;
      odat_r.temperature_centi <= side_r[4].tc;
      odat_r.fine_temperature  <= side_r[4].fine;
      odat_r.pressure_q24_8    <= side_r[4].dz ? 32'd0 : res[31:0];
      odat_r.divide_by_zero    <= side_r[4].dz;
    end
  end

  assign out_valid = ovld_r;
  assign out_data  = odat_r;

endmodule

### tb/barometric_sensor_compensation_test.sv
// Self-checking testbench for the barometric compensation pipeline.
module barometric_sensor_compensation_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bsc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bsc_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bsc_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  barometric_sensor_compensation i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Calibration as the predictor sees it; updated on each accepted write to a known index.
  logic [47:0] temp_cal = '0;
  logic [47:0] press_a = '0;
  logic [47:0] press_b = '0;
  logic [47:0] press_c = '0;

  bsc_pkg::in_item_t  pending_readings[$];  // waiting to be driven
  bsc_pkg::out_item_t expected_results[$];  // predicted, waiting for the output
  int        mismatches = 0;

  // Sender burst/gap control and receiver stall control.
  int  burst_left = 0;
  int  gap_left = 0;
  int  stall_pct = 0;       // receiver stall probability in percent
  int  hold_reqs = 0;       // long holds requested by the stimulus
  int  hold_done = 0;       // long holds started by the receiver
  int  hold_left = 0;
  logic in_took = 1'b0;     // current input transaction accepted at last edge

  function automatic logic [63:0] sext16(logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  // Integer compensation: 32-bit wrapping temperature path, then the
  // 64-bit pressure polynomial with truncating signed division.
  function automatic bsc_pkg::out_item_t compensate(bsc_pkg::in_item_t x);
    logic [31:0] adc_t, t1, t2, t3, a, d, b, fine, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, tmp, num, an, ad, q, ps, w1, w2, pr;
    bsc_pkg::out_item_t r;
    adc_t = {12'd0, x.raw_temperature};
    t1 = {16'd0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    a = (adc_t >> 3) - (t1 << 1);
    a = a * t2;
    a = $signed(a) >>> 11;
    d = (adc_t >> 4) - t1;
    b = d * d;
    b = $signed(b) >>> 12;
    b = b * t3;
    b = $signed(b) >>> 14;
    fine = a + b;
    tc = fine * 32'd5 + 32'd128;
    tc = $signed(tc) >>> 8;

    p1 = {48'd0, press_a[15:0]};
    p2 = sext16(press_a[31:16]);
    p3 = sext16(press_a[47:32]);
    p4 = sext16(press_b[15:0]);
    p5 = sext16(press_b[31:16]);
    p6 = sext16(press_b[47:32]);
    p7 = sext16(press_c[15:0]);
    p8 = sext16(press_c[31:16]);
    p9 = sext16(press_c[47:32]);

    v1 = {{32{fine[31]}}, fine} - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    tmp = v1 * v1 * p3;
    tmp = $signed(tmp) >>> 8;
    v1 = tmp + ((v1 * p2) << 12);
    v1 = ((64'd1 << 47) + v1) * p1;
    v1 = $signed(v1) >>> 33;

    r.temperature_centi = tc[23:0];
    r.fine_temperature = fine;
    if (v1 == 64'd0) begin
      r.pressure_q24_8 = '0;
      r.divide_by_zero = 1'b1;
    end else begin
      num = ((64'd1048576 - {44'd0, x.raw_pressure}) << 31) - v2;
      num = num * 64'd3125;
      an = num[63] ? -num : num;
      ad = v1[63] ? -v1 : v1;
      q = an / ad;
      if (num[63] != v1[63]) q = -q;
      ps = $signed(q) >>> 13;
      w1 = p9 * ps * ps;
      w1 = $signed(w1) >>> 25;
      w2 = p8 * q;
      w2 = $signed(w2) >>> 19;
      pr = q + w1 + w2;
      pr = $signed(pr) >>> 8;
      pr = pr + (p7 << 4);
      r.pressure_q24_8 = pr[31:0];
      r.divide_by_zero = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  // Sample side: predict on input transactions, check output transactions,
  // track calibration writes.
  always @(posedge clk) begin
    bsc_pkg::out_item_t want;
    in_took <= in_valid && in_ready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bsc_pkg::REG_TEMP_CAL: temp_cal <= cfg_data;
          bsc_pkg::REG_PRESS_A:  press_a  <= cfg_data;
          bsc_pkg::REG_PRESS_B:  press_b  <= cfg_data;
          bsc_pkg::REG_PRESS_C:  press_c  <= cfg_data;
          default: ;  // unknown index: dropped
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(compensate(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction", 64'(out_data.pressure_q24_8), 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_data.temperature_centi !== want.temperature_centi)
            report_mismatch("temperature_centi", 64'(out_data.temperature_centi),
                            64'(want.temperature_centi));
          if (out_data.fine_temperature !== want.fine_temperature)
            report_mismatch("fine_temperature", 64'(out_data.fine_temperature),
                            64'(want.fine_temperature));
          if (out_data.pressure_q24_8 !== want.pressure_q24_8)
            report_mismatch("pressure_q24_8", 64'(out_data.pressure_q24_8),
                            64'(want.pressure_q24_8));
          if (out_data.divide_by_zero !== want.divide_by_zero)
            report_mismatch("divide_by_zero", 64'(out_data.divide_by_zero),
                            64'(want.divide_by_zero));
        end
      end
    end
  end

  // Input driver: bursts of random length with random gaps; payload holds
  // until the transaction is taken.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_took)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_readings.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_readings.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output receiver: random stalls at the phase's rate, plus one long hold
  // per request so the pipeline backs up into in_ready.
  always @(negedge clk) begin
    if (hold_done < hold_reqs && hold_left == 0) begin
      hold_left <= 300;
      hold_done <= hold_done + 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_reg(logic [bsc_pkg::CFG_IDX_W-1:0] idx, logic [47:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_calibration(logic [47:0] tc, logic [47:0] pa,
                                  logic [47:0] pb, logic [47:0] pc);
    write_reg(bsc_pkg::REG_TEMP_CAL, tc);
    write_reg(bsc_pkg::REG_PRESS_A, pa);
    write_reg(bsc_pkg::REG_PRESS_B, pb);
    write_reg(bsc_pkg::REG_PRESS_C, pc);
  endtask

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Raw readings: mostly near a normal operating point, the rest anywhere.
  function automatic bsc_pkg::in_item_t random_reading();
    bsc_pkg::in_item_t x;
    if ($urandom_range(0, 9) < 6) begin
      x.raw_temperature = 20'd519888 + 20'($urandom_range(0, 65535)) - 20'd32768;
      x.raw_pressure = 20'd415148 + 20'($urandom_range(0, 65535)) - 20'd32768;
    end else begin
      x.raw_temperature = 20'($urandom());
      x.raw_pressure = 20'($urandom());
    end
    return x;
  endfunction

  task automatic run_readings(int count, int stall);
    stall_pct = stall;
    for (int i = 0; i < count; i++) pending_readings.push_back(random_reading());
    if (stall > 0) hold_reqs++;
    wait (pending_readings.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (100) @(negedge clk);
  endtask

  // Typical factory calibration of such a sensor.
  localparam logic [47:0] CAL_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] CAL_PA = {16'd3024, 16'hD643, 16'd36477};
  localparam logic [47:0] CAL_PB = {16'hFFF9, 16'd140, 16'd2855};
  localparam logic [47:0] CAL_PC = {16'd6000, 16'hC6F8, 16'd15500};

  initial begin
    bsc_pkg::in_item_t x;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: P1 is zero, so every transaction divides by zero.
    x = '0;                          pending_readings.push_back(x);
    x = '1;                          pending_readings.push_back(x);
    // Typical calibration with field extremes and one normal reading.
    wait (pending_readings.size() == 0 && !in_valid && expected_results.size() == 0);
    repeat (100) @(negedge clk);
    load_calibration(CAL_T, CAL_PA, CAL_PB, CAL_PC);
    write_reg(8'd4, '1);             // out-of-range index: ignored
    write_reg(8'hFF, '0);
    x.raw_temperature = 20'd519888; x.raw_pressure = 20'd415148;
    pending_readings.push_back(x);
    for (int i = 0; i < 4; i++) begin
      x.raw_temperature = i[0] ? '1 : '0;
      x.raw_pressure = i[1] ? '1 : '0;
      pending_readings.push_back(x);
    end
    x.raw_temperature = 20'h80000; x.raw_pressure = 20'h7FFFF;
    pending_readings.push_back(x);
    run_readings(200, 0);

    // All-ones calibration: every signed word is -1, P1 at its maximum.
    load_calibration('1, '1, '1, '1);
    x = '0; pending_readings.push_back(x);
    x = '1; pending_readings.push_back(x);
    run_readings(150, 50);

    // Most negative signed words but P7 to P9 at their maximum, and P1 = 1.
    load_calibration({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h0001},
                     {3{16'h8000}}, {3{16'h7FFF}});
    run_readings(100, 20);

    // Zero pressure words only: divisor is zero again with live temperature.
    load_calibration(CAL_T, 48'd0, 48'd0, 48'd0);
    run_readings(50, 10);

    // Random calibrations.
    for (int ph = 0; ph < 4; ph++) begin
      load_calibration(rand48(), rand48(), rand48(), rand48());
      run_readings(150, $urandom_range(0, 70));
    end
    load_calibration(CAL_T, CAL_PA, CAL_PB, CAL_PC);
    run_readings(200, 30);

    if (mismatches == 0) begin
      $display("[barometric_sensor_compensation] OK");
    end else begin
      $display("[barometric_sensor_compensation] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[barometric_sensor_compensation] ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/core/bsc_pkg.sv
rtl/core/bsc_temp.sv
rtl/core/bsc_coef.sv
rtl/core/bsc_div.sv
rtl/core/bsc_post.sv
rtl/core/barometric_sensor_compensation.sv
tb/barometric_sensor_compensation_test.sv
